// ----- rtl/core/cps_pkg.sv -----
// Package for the Chaikin path smoother: field widths, transaction
// payload structs, command kinds and sequencer steps.
// No dependencies.
package cps_pkg;

   localparam int CoordWidth = 32;
   localparam int DiffWidth  = CoordWidth + 1;
   localparam int AlphaWidth = 17;
   localparam int ProdWidth  = DiffWidth + AlphaWidth + 1;
   localparam int FracShift  = 16;

   localparam logic [AlphaWidth-1:0] OneQ16       = 17'h10000;
   localparam logic [AlphaWidth-1:0] AlphaDefault = 17'd49152;
   localparam logic                  EnableDefault = 1'b1;

   // Register indexes of the configuration port
   localparam int CsrIndexWidth = 1;
   localparam logic [CsrIndexWidth-1:0] CsrEnable = 1'b0;
   localparam logic [CsrIndexWidth-1:0] CsrAlpha  = 1'b1;

   // Default queue depths
   localparam int CmdDepthDefault = 2;
   localparam int RspDepthDefault = 4;

   typedef struct packed {
      logic signed [CoordWidth-1:0] in_x;
      logic signed [CoordWidth-1:0] in_y;
      logic signed [CoordWidth-1:0] in_z;
      logic                         in_end;
   } req_type;

   typedef struct packed {
      logic signed [CoordWidth-1:0] out_x;
      logic signed [CoordWidth-1:0] out_y;
      logic signed [CoordWidth-1:0] out_z;
      logic                         out_end;
   } rsp_type;

   // What the back end has to do for one accepted point
   typedef enum logic [1:0] {
      CMD_PASS,       // emit the point as is
      CMD_BLEND,      // emit p1 and p2
      CMD_BLEND_END   // emit p1, p2 and the final point
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type                 kind;
      logic                         last_pt;
      logic signed [CoordWidth-1:0] cur_x;
      logic signed [CoordWidth-1:0] cur_y;
      logic signed [CoordWidth-1:0] cur_z;
      logic signed [DiffWidth-1:0]  diff_x;
      logic signed [DiffWidth-1:0]  diff_y;
      logic signed [DiffWidth-1:0]  diff_z;
   } cmd_type;

   typedef enum logic [1:0] {
      STEP_P1,
      STEP_P2,
      STEP_FINAL
   } step_type;

endpackage

// ----- rtl/core/cps_fifo.sv -----
// Small synchronous FIFO on a register array with fill count.
// Used for the command queue and the result queue; no package use.
module cps_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  logic [WIDTH-1:0]           push_data,
   input  logic                       pop,
   output logic [WIDTH-1:0]           head_data,
   output logic [$clog2(DEPTH+1)-1:0] count
);

   localparam int PtrWidth   = $clog2(DEPTH);
   localparam int CountWidth = $clog2(DEPTH+1);
   localparam logic [PtrWidth-1:0]   LastPtr = PtrWidth'(DEPTH - 1);
   localparam logic [CountWidth-1:0] FullCnt = CountWidth'(DEPTH);

   logic [WIDTH-1:0]      mem_ff [DEPTH];
   logic [PtrWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CountWidth-1:0] count_ff, count_in;
   logic                  do_push, do_pop;

   // Guard against overrun and underrun
   assign do_push = push && (count_ff != FullCnt);
   assign do_pop  = pop && (count_ff != '0);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage, no reset
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head_data = mem_ff[rd_ptr_ff];
   assign count     = count_ff;

endmodule

// ----- rtl/core/cps_front.sv -----
// Front end: accepts points, tracks the open path and classifies each
// point into a command for the back end. Depends on cps_pkg.
module cps_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             enable,
   input  logic             accept,
   input  cps_pkg::req_type req,
   output cps_pkg::cmd_type cmd
);

   logic                                  have_prev_ff, have_prev_in;
   logic signed [cps_pkg::CoordWidth-1:0] prev_x_ff, prev_y_ff, prev_z_ff;
   logic signed [cps_pkg::CoordWidth-1:0] prev_x_in, prev_y_in, prev_z_in;

   // Classify and update path state
   always_comb begin
      have_prev_in = have_prev_ff;
      prev_x_in    = prev_x_ff;
      prev_y_in    = prev_y_ff;
      prev_z_in    = prev_z_ff;
      cmd.kind     = cps_pkg::CMD_PASS;
      cmd.last_pt  = req.in_end;
      cmd.cur_x    = req.in_x;
      cmd.cur_y    = req.in_y;
      cmd.cur_z    = req.in_z;
      cmd.diff_x   = cps_pkg::DiffWidth'(prev_x_ff) - cps_pkg::DiffWidth'(req.in_x);
      cmd.diff_y   = cps_pkg::DiffWidth'(prev_y_ff) - cps_pkg::DiffWidth'(req.in_y);
      cmd.diff_z   = cps_pkg::DiffWidth'(prev_z_ff) - cps_pkg::DiffWidth'(req.in_z);
      if (accept) begin
         priority if (!enable) begin
            have_prev_in = 1'b0;
         end else if (!have_prev_ff) begin
            if (!req.in_end) begin
               have_prev_in = 1'b1;
               prev_x_in    = req.in_x;
               prev_y_in    = req.in_y;
               prev_z_in    = req.in_z;
            end
         end else begin
            cmd.kind = req.in_end ? cps_pkg::CMD_BLEND_END : cps_pkg::CMD_BLEND;
            if (req.in_end) begin
               have_prev_in = 1'b0;
            end else begin
               prev_x_in = req.in_x;
               prev_y_in = req.in_y;
               prev_z_in = req.in_z;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         have_prev_ff <= 1'b0;
         prev_x_ff    <= '0;
         prev_y_ff    <= '0;
         prev_z_ff    <= '0;
      end else begin
         have_prev_ff <= have_prev_in;
         prev_x_ff    <= prev_x_in;
         prev_y_ff    <= prev_y_in;
         prev_z_ff    <= prev_z_in;
      end
   end

`ifndef SYNTHESIS
   a_disable_drops_path: assert property (@(posedge clock) disable iff (reset)
      (accept && !enable) |=> !have_prev_ff)
      else $error("open path kept while smoothing disabled");
   a_end_closes_path: assert property (@(posedge clock) disable iff (reset)
      (accept && req.in_end) |=> !have_prev_ff)
      else $error("path still open after end point");
   a_blend_needs_prev: assert property (@(posedge clock) disable iff (reset)
      (accept && cmd.kind != cps_pkg::CMD_PASS) |-> (have_prev_ff && enable))
      else $error("blend issued without previous point");
`endif

endmodule

// ----- rtl/core/cps_back.sv -----
// Back end: steps through each command, one output point per cycle while the result
// queue has room, through a multiply stage and a round stage. Depends on cps_pkg.
module cps_back #(
   parameter int RSP_DEPTH = cps_pkg::RspDepthDefault
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic [cps_pkg::AlphaWidth-1:0]        alpha,
   input  cps_pkg::cmd_type                      cmd_head,
   input  logic                                  cmd_valid,
   output logic                                  cmd_pop,
   input  logic [$clog2(RSP_DEPTH+1)-1:0]        rsp_count,
   output logic                                  rsp_push,
   output cps_pkg::rsp_type                      rsp_data
);

   localparam int PW = cps_pkg::ProdWidth;
   localparam int CW = cps_pkg::CoordWidth;
   localparam int FS = cps_pkg::FracShift;

   cps_pkg::step_type step_ff, step_in;

   logic                          issue, credit_ok, is_last, end_sel;
   logic [cps_pkg::AlphaWidth-1:0] a_w, w_sel;
   logic signed [PW-1:0]          prod_x_in, prod_y_in, prod_z_in;
   logic signed [PW-1:0]          prod_x_ff, prod_y_ff, prod_z_ff;
   logic signed [CW-1:0]          cur_x_ff, cur_y_ff, cur_z_ff;
   logic                          end_ff;
   logic                          s1_valid_ff;
   logic signed [PW-1:0]          sum_x, sum_y, sum_z;

   // Room in the result queue counting the point in flight
   assign credit_ok = (32'(rsp_count) + 32'(s1_valid_ff)) < RSP_DEPTH;
   assign issue     = cmd_valid && credit_ok;
   assign a_w       = (alpha > cps_pkg::OneQ16) ? cps_pkg::OneQ16 : alpha;

   // Step sequencer: weight and end flag of the current output point
   always_comb begin
      w_sel   = '0;
      end_sel = 1'b0;
      is_last = 1'b1;
      unique case (step_ff)
         cps_pkg::STEP_P1: begin
            if (cmd_head.kind == cps_pkg::CMD_PASS) begin
               end_sel = cmd_head.last_pt;
            end else begin
               w_sel   = a_w;
               is_last = 1'b0;
            end
         end
         cps_pkg::STEP_P2: begin
            w_sel   = cps_pkg::OneQ16 - a_w;
            is_last = (cmd_head.kind != cps_pkg::CMD_BLEND_END);
         end
         cps_pkg::STEP_FINAL: begin
            end_sel = 1'b1;
         end
         default: begin
            is_last = 1'b1;
         end
      endcase

      step_in = step_ff;
      if (issue) begin
         if (is_last) begin
            step_in = cps_pkg::STEP_P1;
         end else if (step_ff == cps_pkg::STEP_P1) begin
            step_in = cps_pkg::STEP_P2;
         end else begin
            step_in = cps_pkg::STEP_FINAL;
         end
      end
   end

   assign cmd_pop = issue && is_last;

   // Blend = cur + (prev - cur) * w, product stage
   assign prod_x_in = cmd_head.diff_x * $signed({1'b0, w_sel});
   assign prod_y_in = cmd_head.diff_y * $signed({1'b0, w_sel});
   assign prod_z_in = cmd_head.diff_z * $signed({1'b0, w_sel});

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff     <= cps_pkg::STEP_P1;
         s1_valid_ff <= 1'b0;
      end else begin
         step_ff     <= step_in;
         s1_valid_ff <= issue;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         prod_x_ff <= prod_x_in;
         prod_y_ff <= prod_y_in;
         prod_z_ff <= prod_z_in;
         cur_x_ff  <= cmd_head.cur_x;
         cur_y_ff  <= cmd_head.cur_y;
         cur_z_ff  <= cmd_head.cur_z;
         end_ff    <= end_sel;
      end
   end

   // Round stage: add cur in Q24.24 plus half an LSB, floor to Q24.8
   assign sum_x = PW'({cur_x_ff, 16'h8000}) + prod_x_ff;
   assign sum_y = PW'({cur_y_ff, 16'h8000}) + prod_y_ff;
   assign sum_z = PW'({cur_z_ff, 16'h8000}) + prod_z_ff;

   assign rsp_push         = s1_valid_ff;
   assign rsp_data.out_x   = sum_x[FS+CW-1:FS];
   assign rsp_data.out_y   = sum_y[FS+CW-1:FS];
   assign rsp_data.out_z   = sum_z[FS+CW-1:FS];
   assign rsp_data.out_end = end_ff;

`ifndef SYNTHESIS
   a_no_rsp_overrun: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |-> (32'(rsp_count) < RSP_DEPTH))
      else $error("result queue overrun");
   a_cmd_held_mid_step: assert property (@(posedge clock) disable iff (reset)
      (step_ff != cps_pkg::STEP_P1) |-> cmd_valid)
      else $error("command lost in the middle of its steps");
   a_final_only_on_end: assert property (@(posedge clock) disable iff (reset)
      (step_ff == cps_pkg::STEP_FINAL) |-> (cmd_head.kind == cps_pkg::CMD_BLEND_END))
      else $error("final step on a command without path end");
`endif

endmodule

// ----- rtl/core/chaikin_path_smoother.sv -----
// Chaikin path smoother, one corner-cutting pass over a stream of points.
// A result passes the command queue, the back end's multiply stage register and the
// result queue. Throughput: one result per cycle while the result queue has room;
// an interior point gives two results, a passed point one and a closing path end three.
// Reset: synchronous, clears queues and path state; smoothing on, alpha 0.75.
// Uses cps_pkg, cps_fifo, cps_front and cps_back.
module chaikin_path_smoother #(
   parameter int CMD_DEPTH = cps_pkg::CmdDepthDefault,
   parameter int RSP_DEPTH = cps_pkg::RspDepthDefault
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_push,
   input  cps_pkg::req_type                     req_data,
   output logic                                 req_full,
   output logic                                 rsp_empty,
   input  logic                                 rsp_pop,
   output cps_pkg::rsp_type                     rsp_data,
   input  logic                                 csr_we,
   input  logic [cps_pkg::CsrIndexWidth-1:0]    csr_index,
   input  logic [cps_pkg::AlphaWidth-1:0]       csr_wdata
);

   localparam int CmdBits = $bits(cps_pkg::cmd_type);
   localparam int RspBits = $bits(cps_pkg::rsp_type);

   logic                            enable_ff;
   logic [cps_pkg::AlphaWidth-1:0]  alpha_ff;
   logic                            accept;
   cps_pkg::cmd_type                cmd_new, cmd_head;
   logic [CmdBits-1:0]              cmd_head_bits;
   logic [$clog2(CMD_DEPTH+1)-1:0]  cmd_count;
   logic                            cmd_pop;
   logic [$clog2(RSP_DEPTH+1)-1:0]  rsp_count;
   logic                            rsp_push;
   cps_pkg::rsp_type                rsp_new;
   logic [RspBits-1:0]              rsp_head_bits;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= cps_pkg::EnableDefault;
         alpha_ff  <= cps_pkg::AlphaDefault;
      end else if (csr_we) begin
         unique case (csr_index)
            cps_pkg::CsrEnable: enable_ff <= csr_wdata[0];
            cps_pkg::CsrAlpha:  alpha_ff  <= csr_wdata;
            default:            enable_ff <= enable_ff;
         endcase
      end
   end

   assign req_full = (32'(cmd_count) == CMD_DEPTH);
   assign accept   = req_push && !req_full;

   cps_front u_front (
      .clock  (clock),
      .reset  (reset),
      .enable (enable_ff),
      .accept (accept),
      .req    (req_data),
      .cmd    (cmd_new)
   );

   cps_fifo #(
      .WIDTH (CmdBits),
      .DEPTH (CMD_DEPTH)
   ) u_cmd_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_data (cmd_new),
      .pop       (cmd_pop),
      .head_data (cmd_head_bits),
      .count     (cmd_count)
   );

   assign cmd_head = cps_pkg::cmd_type'(cmd_head_bits);

   cps_back #(
      .RSP_DEPTH (RSP_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .alpha     (alpha_ff),
      .cmd_head  (cmd_head),
      .cmd_valid (cmd_count != '0),
      .cmd_pop   (cmd_pop),
      .rsp_count (rsp_count),
      .rsp_push  (rsp_push),
      .rsp_data  (rsp_new)
   );

   cps_fifo #(
      .WIDTH (RspBits),
      .DEPTH (RSP_DEPTH)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_data (rsp_new),
      .pop       (rsp_pop && !rsp_empty),
      .head_data (rsp_head_bits),
      .count     (rsp_count)
   );

   assign rsp_empty = (rsp_count == '0);
   assign rsp_data  = cps_pkg::rsp_type'(rsp_head_bits);

endmodule

// ----- bench/tb.sv -----
// Testbench for chaikin_path_smoother: streams 3D path points through the block,
// predicts every smoothed point and checks each result transaction in order.
// Depends on cps_pkg and the chaikin_path_smoother RTL.
module tb;

   localparam int WatchdogLimit = 3000;   // cycles without any transaction
   localparam int HoldCycles    = 80;     // long receiver hold-off
   localparam int SettleCycles  = 10;     // quiet time after the last result

   logic                                  clock;
   logic                                  reset     = 1'b1;
   logic                                  req_push  = 1'b0;
   cps_pkg::req_type                      req_data  = '0;
   logic                                  req_full;
   logic                                  rsp_empty;
   logic                                  rsp_pop   = 1'b0;
   cps_pkg::rsp_type                      rsp_data;
   logic                                  csr_we    = 1'b0;
   logic [cps_pkg::CsrIndexWidth-1:0]     csr_index = '0;
   logic [cps_pkg::AlphaWidth-1:0]        csr_wdata = '0;

   // Predictor state: settings and the open path
   logic                                  smooth_on = cps_pkg::EnableDefault;
   logic [cps_pkg::AlphaWidth-1:0]        weight    = cps_pkg::AlphaDefault;
   logic signed [cps_pkg::CoordWidth-1:0] last_x    = '0;
   logic signed [cps_pkg::CoordWidth-1:0] last_y    = '0;
   logic signed [cps_pkg::CoordWidth-1:0] last_z    = '0;
   logic                                  path_open = 1'b0;

   cps_pkg::rsp_type expected_pts[$];
   int      error_count  = 0;
   bit      idle_on      = 1'b0;
   bit      hold_req     = 1'b0;
   int      hold_left    = 0;
   int      stall_left   = 0;
   int      quiet_cycles = 0;

   chaikin_path_smoother u_top (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_data  (req_data),
      .req_full  (req_full),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Weighted mix of two coordinates, Q24.24 rounded to Q24.8, ties upward
   function automatic logic signed [cps_pkg::CoordWidth-1:0] corner_mix(
      input logic signed [cps_pkg::CoordWidth-1:0] p,
      input logic signed [cps_pkg::CoordWidth-1:0] c,
      input longint wp,
      input longint wc);
      longint acc;
      acc = longint'(p) * wp + longint'(c) * wc + 64'sd32768;
      return cps_pkg::CoordWidth'(acc >>> cps_pkg::FracShift);
   endfunction

   // Expected output points for one accepted input point
   task automatic smooth_predict(input cps_pkg::req_type pt);
      cps_pkg::rsp_type pt_out;
      longint  wa;
      longint  wb;
      if (!smooth_on) begin
         path_open = 1'b0;
         pt_out = '{pt.in_x, pt.in_y, pt.in_z, pt.in_end};
         expected_pts.push_back(pt_out);
      end else if (!path_open) begin
         pt_out = '{pt.in_x, pt.in_y, pt.in_z, pt.in_end};
         expected_pts.push_back(pt_out);
         if (!pt.in_end) begin
            last_x = pt.in_x;
            last_y = pt.in_y;
            last_z = pt.in_z;
            path_open = 1'b1;
         end
      end else begin
         // weight above 1.0 saturates at 1.0
         wa = (weight > cps_pkg::OneQ16) ? cps_pkg::OneQ16 : weight;
         wb = longint'(cps_pkg::OneQ16) - wa;
         pt_out = '{corner_mix(last_x, pt.in_x, wa, wb), corner_mix(last_y, pt.in_y, wa, wb),
                    corner_mix(last_z, pt.in_z, wa, wb), 1'b0};
         expected_pts.push_back(pt_out);
         pt_out = '{corner_mix(last_x, pt.in_x, wb, wa), corner_mix(last_y, pt.in_y, wb, wa),
                    corner_mix(last_z, pt.in_z, wb, wa), 1'b0};
         expected_pts.push_back(pt_out);
         if (pt.in_end) begin
            pt_out = '{pt.in_x, pt.in_y, pt.in_z, 1'b1};
            expected_pts.push_back(pt_out);
            path_open = 1'b0;
         end else begin
            last_x = pt.in_x;
            last_y = pt.in_y;
            last_z = pt.in_z;
         end
      end
   endtask

   // Offer one point, with an occasional idle burst first, until accepted
   task automatic send_point(input logic signed [cps_pkg::CoordWidth-1:0] x,
                             input logic signed [cps_pkg::CoordWidth-1:0] y,
                             input logic signed [cps_pkg::CoordWidth-1:0] z,
                             input logic last);
      int gap;
      if (idle_on && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 12);
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push <= 1'b1;
      req_data <= '{x, y, z, last};
      do @(posedge clock); while (req_full !== 1'b0);
      smooth_predict(req_data);
   endtask

   // Stop offering and wait until every predicted point came back
   task automatic wait_all_returned();
      req_push <= 1'b0;
      while (expected_pts.size() != 0) @(posedge clock);
   endtask

   // Write both registers back to back; only called while the block is idle
   task automatic configure(input logic enable,
                            input logic [cps_pkg::AlphaWidth-1:0] alpha_val);
      csr_we    <= 1'b1;
      csr_index <= cps_pkg::CsrEnable;
      csr_wdata <= {{(cps_pkg::AlphaWidth-1){1'b0}}, enable};
      @(posedge clock);
      smooth_on = enable;
      csr_index <= cps_pkg::CsrAlpha;
      csr_wdata <= alpha_val;
      @(posedge clock);
      weight = alpha_val;
      csr_we <= 1'b0;
   endtask

   function automatic logic signed [cps_pkg::CoordWidth-1:0] rand_coord();
      int unsigned pick;
      case ($urandom_range(0, 5))
         0: return $urandom_range(0, 4095) - 2048;
         1: begin
            pick = $urandom_range(0, 3);
            return (pick == 0) ? 32'sh7FFFFFFF :
                   (pick == 1) ? 32'sh80000000 :
                   (pick == 2) ? 32'sh00000000 : 32'shFFFFFFFF;
         end
         default: return $urandom();
      endcase
   endfunction

   // Mostly well-formed paths of 1 to 8 points; some end flags are random
   task automatic send_paths(input int count);
      int   seg_left = 0;
      logic last;
      for (int i = 0; i < count; i++) begin
         if (seg_left == 0) seg_left = $urandom_range(1, 8);
         seg_left--;
         last = (seg_left == 0);
         if ($urandom_range(0, 9) == 0) last = 1'($urandom_range(0, 1));
         if (last) seg_left = 0;
         send_point(rand_coord(), rand_coord(), rand_coord(), last);
      end
   endtask

   // Default settings: three-point path, then a single-point path
   task automatic test_default_path();
      send_point(32'sd0, 32'sd0, 32'sd0, 1'b0);
      send_point(32'sd256, -32'sd512, 32'sd1024, 1'b0);
      send_point(32'sd1000, 32'sd2000, -32'sd3000, 1'b1);
      send_point(32'sd5, 32'sd6, 32'sd7, 1'b1);
      wait_all_returned();
   endtask

   // Half weight puts results on exact halves, positive and negative
   task automatic test_rounding_ties();
      configure(1'b1, 17'd32768);
      send_point(32'sd1, -32'sd1, 32'sd3, 1'b0);
      send_point(32'sd0, 32'sd0, 32'sd0, 1'b0);
      send_point(-32'sd3, 32'sd5, -32'sd1, 1'b1);
      wait_all_returned();
   endtask

   // Full-scale coordinates at weight zero, one and above one
   task automatic test_extreme_coords();
      configure(1'b1, '0);
      send_point(32'sh7FFFFFFF, 32'sh80000000, 32'sd0, 1'b0);
      send_point(32'sh80000000, 32'sh7FFFFFFF, -32'sd1, 1'b1);
      wait_all_returned();
      configure(1'b1, cps_pkg::OneQ16);
      send_point(32'sh7FFFFFFF, 32'sh80000000, 32'sd0, 1'b0);
      send_point(32'sh80000000, 32'sh7FFFFFFF, -32'sd1, 1'b1);
      wait_all_returned();
      configure(1'b1, 17'h1FFFF);
      send_point(32'sh80000000, -32'sd1, 32'sh7FFFFFFF, 1'b0);
      send_point(32'sh7FFFFFFF, 32'sd0, 32'sh80000000, 1'b1);
      wait_all_returned();
   endtask

   // Smoothing off passes points; turning it off drops an open path
   task automatic test_passthrough();
      configure(1'b0, cps_pkg::AlphaDefault);
      send_point(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 1'b1);
      send_point(32'sh80000000, 32'sh80000000, 32'sh80000000, 1'b0);
      send_point(32'sd77, -32'sd77, 32'sd0, 1'b0);
      wait_all_returned();
      configure(1'b1, cps_pkg::AlphaDefault);
      send_point(32'sd100, 32'sd200, 32'sd300, 1'b0);
      send_point(32'sd400, 32'sd500, 32'sd600, 1'b0);
      wait_all_returned();
      configure(1'b0, cps_pkg::AlphaDefault);
      send_point(32'sd9, 32'sd8, 32'sd7, 1'b0);
      wait_all_returned();
      configure(1'b1, 17'd16384);
      send_point(-32'sd9, -32'sd8, -32'sd7, 1'b1);
      wait_all_returned();
   endtask

   // Receiver holds off while points keep coming, so the block fills up
   task automatic test_stall_fill();
      bit saved_idle;
      saved_idle = idle_on;
      idle_on = 1'b0;
      configure(1'b1, cps_pkg::AlphaDefault);
      hold_req = 1'b1;
      send_paths(16);
      wait_all_returned();
      idle_on = saved_idle;
   endtask

   // Random paths over several settings, the extremes among them
   task automatic test_random_paths();
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: configure(1'b1, cps_pkg::AlphaWidth'($urandom_range(0, cps_pkg::OneQ16)));
            1: configure(1'b1, '0);
            2: configure(1'b1, cps_pkg::OneQ16);
            3: configure(1'b1, cps_pkg::AlphaWidth'(
                  $urandom_range(cps_pkg::OneQ16 + 1, 17'h1FFFF)));
            4: configure(1'b0, cps_pkg::AlphaWidth'($urandom_range(0, 17'h1FFFF)));
            default: configure(1'b1, cps_pkg::AlphaWidth'($urandom_range(0, 17'h1FFFF)));
         endcase
         idle_on = (phase != 2);
         send_paths((phase == 4) ? 10 : 20);
         wait_all_returned();
      end
   endtask

   // Last part: no idling on either side
   task automatic test_streaming();
      idle_on = 1'b0;
      configure(1'b1, cps_pkg::AlphaWidth'($urandom_range(0, cps_pkg::OneQ16)));
      send_paths(30);
      wait_all_returned();
   endtask

   // Receiver: long hold-off on request, otherwise random stall bursts
   always @(posedge clock) begin
      if (hold_req) begin
         hold_left = HoldCycles;
         hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_pop <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_pop <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(0, 11);
         rsp_pop <= 1'b0;
      end else begin
         rsp_pop <= 1'b1;
      end
   end

   // Compare each popped point with the oldest prediction
   always @(posedge clock) begin : check_points
      cps_pkg::rsp_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (expected_pts.size() == 0) begin
            error_count++;
            $display("%0t: unexpected point: expected none, actual x=%0d y=%0d z=%0d end=%0b",
                     $time, rsp_data.out_x, rsp_data.out_y, rsp_data.out_z, rsp_data.out_end);
         end else begin
            want = expected_pts.pop_front();
            if (rsp_data.out_x !== want.out_x || rsp_data.out_y !== want.out_y ||
                rsp_data.out_z !== want.out_z || rsp_data.out_end !== want.out_end) begin
               error_count++;
               $display("%0t: mismatch: exp x=%0d y=%0d z=%0d e=%0b, act x=%0d y=%0d z=%0d e=%0b",
                        $time, want.out_x, want.out_y, want.out_z, want.out_end,
                        rsp_data.out_x, rsp_data.out_y, rsp_data.out_z, rsp_data.out_end);
            end
         end
      end
   end

   // Watchdog: too long without any transaction on either side
   always @(posedge clock) begin
      if ((req_push && !req_full) || (rsp_pop && !rsp_empty)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WatchdogLimit) begin
         $display("%0t: watchdog expired with %0d points outstanding",
                  $time, expected_pts.size());
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      idle_on = 1'b1;
      test_default_path();
      test_rounding_ties();
      test_extreme_coords();
      test_passthrough();
      test_stall_fill();
      test_random_paths();
      test_streaming();
      wait_all_returned();
      repeat (SettleCycles) @(posedge clock);
      if (error_count == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/core/cps_pkg.sv
rtl/core/cps_fifo.sv
rtl/core/cps_front.sv
rtl/core/cps_back.sv
rtl/core/chaikin_path_smoother.sv
bench/tb.sv
